### hdl/lms_pkg.sv
package lms_pkg;

	localparam int MAX_NAME_LEN = 16;
	localparam int DEPTH_BITS = 16;
	localparam int NAME_LEN_W = $clog2(MAX_NAME_LEN + 1);

	localparam int QDEPTH = 4;
	localparam int QPTR_W = $clog2(QDEPTH);
	localparam int QCNT_W = $clog2(QDEPTH + 1);

	localparam int KW_NUM = 5;
	localparam int KW_SPAN = 13;

	localparam logic [7:0] CH_LF = 8'h0A;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_STAR = 8'h2A;
	localparam logic [7:0] CH_PERCENT = 8'h25;
	localparam logic [7:0] CH_DOLLAR = 8'h24;
	localparam logic [7:0] CH_LBRACE = 8'h7B;
	localparam logic [7:0] CH_RBRACE = 8'h7D;
	localparam logic [7:0] CH_BSLASH = 8'h5C;

	typedef enum logic [1:0] {
		CMD_NONE = 2'd0,
		CMD_DNL  = 2'd1,
		CMD_NL   = 2'd2,
		CMD_ITEM = 2'd3
	} cmd_e_t;

	typedef struct packed {
		cmd_e_t     cmd;
		logic       chr_v;
		logic [7:0] chr;
		logic       fin;
	} op_t;

	localparam logic [8*KW_SPAN-1:0] KW_STR [KW_NUM] = '{
		"section", "subsection", "subsubsection", "newline", "item"
	};
	localparam int KW_LEN [KW_NUM] = '{7, 10, 13, 7, 4};
	localparam cmd_e_t KW_CMD [KW_NUM] = '{CMD_DNL, CMD_DNL, CMD_DNL, CMD_NL, CMD_ITEM};

	function automatic logic [7:0] kw_char(input int k, input logic [NAME_LEN_W-1:0] pos);
		int p;
		logic [7:0] r;
		p = int'(pos);
		r = 8'h00;
		if (p < KW_LEN[k]) begin
			r = KW_STR[k][(KW_LEN[k] - 1 - p) * 8 +: 8];
		end
		return r;
	endfunction

	function automatic cmd_e_t cmd_of(input logic [NAME_LEN_W-1:0] len, input logic ovf,
			input logic [KW_NUM-1:0] match);
		cmd_e_t r;
		r = CMD_NONE;
		for (int k = KW_NUM - 1; k >= 0; k--) begin
			if (match[k] && (len == NAME_LEN_W'(KW_LEN[k]))) begin
				r = KW_CMD[k];
			end
		end
		if (ovf) begin
			r = CMD_NONE;
		end
		return r;
	endfunction

	function automatic logic [2:0] cmd_len(input cmd_e_t c);
		logic [2:0] r;
		case (c)
			CMD_DNL: r = 3'd2;
			CMD_NL: r = 3'd1;
			CMD_ITEM: r = 3'd5;
			default: r = 3'd0;
		endcase
		return r;
	endfunction

	function automatic logic [7:0] cmd_char(input cmd_e_t c, input logic [2:0] idx);
		logic [7:0] r;
		r = CH_LF;
		if (c == CMD_ITEM) begin
			case (idx)
				3'd1, 3'd2, 3'd4: r = CH_SPACE;
				3'd3: r = CH_STAR;
				default: r = CH_LF;
			endcase
		end
		return r;
	endfunction

endpackage

### hdl/lms_front.sv
module lms_front
	import lms_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	input  logic       in_ready,
	input  logic [7:0] in_char,
	input  logic       in_fin,
	output logic       push,
	output op_t        op
);

	typedef enum logic [2:0] {
		MODE_NORMAL  = 3'b001,
		MODE_COMMENT = 3'b010,
		MODE_COMMAND = 3'b100
	} mode_t;

	mode_t                   mode_q, mode_d;
	logic [NAME_LEN_W-1:0]   len_q, len_d;
	logic                    ovf_q, ovf_d;
	logic [KW_NUM-1:0]       match_q, match_d;
	logic [DEPTH_BITS-1:0]   depth_q, depth_d;
	logic                    is_letter;
	logic                    run_normal;
	cmd_e_t                  cmd;
	logic                    chr_v;
	logic [7:0]              chr;

	assign is_letter = ((in_char >= 8'h41) && (in_char <= 8'h5A)) ||
		((in_char >= 8'h61) && (in_char <= 8'h7A));

	always_comb begin
		mode_d = mode_q;
		len_d = len_q;
		ovf_d = ovf_q;
		match_d = match_q;
		depth_d = depth_q;
		cmd = CMD_NONE;
		chr_v = 1'b0;
		chr = 8'h00;
		run_normal = 1'b0;

		case (mode_q)
			MODE_COMMENT: begin
				if (in_char == CH_LF) begin
					mode_d = MODE_NORMAL;
				end
			end
			MODE_COMMAND: begin
				if (is_letter) begin
					if (len_q < NAME_LEN_W'(MAX_NAME_LEN)) begin
						for (int k = 0; k < KW_NUM; k++) begin
							match_d[k] = match_q[k] && (in_char == kw_char(k, len_q));
						end
						len_d = len_q + 1'b1;
					end else begin
						ovf_d = 1'b1;
					end
					if (in_fin) begin
						cmd = cmd_of(len_d, ovf_d, match_d);
						mode_d = MODE_NORMAL;
					end
				end else begin
					cmd = cmd_of(len_q, ovf_q, match_q);
					mode_d = MODE_NORMAL;
					run_normal = 1'b1;
				end
			end
			default: begin
				run_normal = 1'b1;
			end
		endcase

		if (run_normal) begin
			if (in_char == CH_PERCENT) begin
				chr_v = 1'b1;
				chr = CH_LF;
				mode_d = MODE_COMMENT;
			end else if (in_char == CH_BSLASH) begin
				mode_d = MODE_COMMAND;
				len_d = '0;
				ovf_d = 1'b0;
				match_d = '1;
			end else if (in_char == CH_LBRACE) begin
				if (depth_q != '1) begin
					depth_d = depth_q + 1'b1;
				end
				chr_v = 1'b1;
				chr = in_char;
			end else if (in_char == CH_RBRACE) begin
				if (depth_q != '0) begin
					depth_d = depth_q - 1'b1;
					chr_v = 1'b1;
					chr = in_char;
				end
			end else if (in_char != CH_DOLLAR) begin
				chr_v = 1'b1;
				chr = in_char;
			end
		end

		if (in_fin) begin
			mode_d = MODE_NORMAL;
			len_d = '0;
			ovf_d = 1'b0;
			depth_d = '0;
		end
	end

	assign op.cmd = cmd;
	assign op.chr_v = chr_v;
	assign op.chr = chr;
	assign op.fin = in_fin;
	assign push = in_valid && in_ready && ((cmd != CMD_NONE) || chr_v || in_fin);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_NORMAL;
			len_q <= '0;
			ovf_q <= 1'b0;
			match_q <= '0;
			depth_q <= '0;
		end else if (in_valid && in_ready) begin
			mode_q <= mode_d;
			len_q <= len_d;
			ovf_q <= ovf_d;
			match_q <= match_d;
			depth_q <= depth_d;
		end
	end

endmodule

### hdl/lms_queue.sv
module lms_queue
	import lms_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  op_t  push_op,
	input  logic pop,
	output op_t  head,
	output logic empty,
	output logic full
);

	op_t               mem_q [QDEPTH];
	logic [QPTR_W-1:0] wr_q;
	logic [QPTR_W-1:0] rd_q;
	logic [QCNT_W-1:0] cnt_q;

	assign empty = (cnt_q == '0);
	assign full = (cnt_q == QCNT_W'(QDEPTH));
	assign head = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= push_op;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= '0;
			rd_q <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= wr_q + 1'b1;
			end
			if (pop) begin
				rd_q <= rd_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule

### hdl/lms_back.sv
module lms_back
	import lms_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  op_t        head,
	input  logic       empty,
	output logic       pop,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [7:0] out_char,
	output logic       char_valid,
	output logic       run_last,
	output logic       text_end
);

	op_t        cur_q;
	logic       cur_valid_q;
	logic [2:0] idx_q;
	logic [2:0] clen;
	logic [2:0] total;
	logic [2:0] total_eff;
	logic       fire;
	logic       load;

	assign clen = cmd_len(cur_q.cmd);
	assign total = clen + {2'b00, cur_q.chr_v};
	assign total_eff = (total == 3'd0) ? 3'd1 : total;

	always_comb begin
		if (idx_q < clen) begin
			out_char = cmd_char(cur_q.cmd, idx_q);
			char_valid = 1'b1;
		end else if (cur_q.chr_v) begin
			out_char = cur_q.chr;
			char_valid = 1'b1;
		end else begin
			out_char = 8'h00;
			char_valid = 1'b0;
		end
	end

	assign out_valid = cur_valid_q;
	assign run_last = (idx_q == total_eff - 3'd1);
	assign text_end = run_last && cur_q.fin;
	assign fire = cur_valid_q && out_ready;
	assign load = !cur_valid_q || (fire && run_last);
	assign pop = load && !empty;

	always_ff @(posedge clk) begin
		if (pop) begin
			cur_q <= head;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_valid_q <= 1'b0;
			idx_q <= '0;
		end else if (load) begin
			cur_valid_q <= !empty;
			idx_q <= '0;
		end else if (fire) begin
			idx_q <= idx_q + 1'b1;
		end
	end

endmodule

### hdl/latex_markup_stripper.sv
// Channel  Dir  tdata           tuser                      tlast
// s_axis   in   in_char[7:0]    -                          final_byte
// m_axis   out  out_char[7:0]   char_valid[0] text_end[1]  run_last
//
// A source byte is taken every cycle while the four-entry queue has room.
// Each queued entry leaves as one to six output words, one word per cycle while the output is ready.
// Bytes that produce nothing never enter the queue, except a final byte, which always enters.
// Reset returns the mode, name tracking and brace depth to their idle values.
// A stalled output fills the queue, and then the input stalls.
module latex_markup_stripper
	import lms_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       s_axis_tvalid,
	output logic       s_axis_tready,
	input  logic [7:0] s_axis_tdata,  // in_char[7:0]
	input  logic       s_axis_tlast,
	output logic       m_axis_tvalid,
	input  logic       m_axis_tready,
	output logic [7:0] m_axis_tdata,  // out_char[7:0]
	output logic [1:0] m_axis_tuser,  // char_valid[0], text_end[1]
	output logic       m_axis_tlast
);

	logic push;
	op_t  push_op;
	logic pop;
	op_t  head;
	logic empty;
	logic full;
	logic char_valid;
	logic text_end;

	assign s_axis_tready = !full;

	lms_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.in_ready (s_axis_tready),
		.in_char  (s_axis_tdata),
		.in_fin   (s_axis_tlast),
		.push     (push),
		.op       (push_op)
	);

	lms_queue u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.push_op (push_op),
		.pop     (pop),
		.head    (head),
		.empty   (empty),
		.full    (full)
	);

	lms_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head       (head),
		.empty      (empty),
		.pop        (pop),
		.out_valid  (m_axis_tvalid),
		.out_ready  (m_axis_tready),
		.out_char   (m_axis_tdata),
		.char_valid (char_valid),
		.run_last   (m_axis_tlast),
		.text_end   (text_end)
	);

	assign m_axis_tuser = {text_end, char_valid};

endmodule

### sim/latex_markup_stripper_tb.sv
`timescale 1ns / 1ps

module latex_markup_stripper_tb;
	import lms_pkg::*;

	localparam int STALL_LIMIT = 2000;
	localparam int DRAIN_CYCLES = 20;
	localparam logic [DEPTH_BITS-1:0] DEPTH_TOP = {DEPTH_BITS{1'b1}};

	typedef enum logic [1:0] {
		SCAN_TEXT,
		SCAN_COMMENT,
		SCAN_NAME
	} scan_mode_t;

	typedef struct packed {
		logic [7:0] ch;
		logic       fin;
	} source_byte_t;

	typedef struct packed {
		logic [7:0] out_char;
		logic       char_valid;
		logic       run_last;
		logic       text_end;
	} display_word_t;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       s_axis_tvalid = 1'b0;
	logic       s_axis_tready;
	logic [7:0] s_axis_tdata = 8'h00;
	logic       s_axis_tlast = 1'b0;
	logic       m_axis_tvalid;
	logic       m_axis_tready = 1'b0;
	logic [7:0] m_axis_tdata;
	logic [1:0] m_axis_tuser;
	logic       m_axis_tlast;

	source_byte_t  source_bytes[$];
	display_word_t display_words[$];
	logic [7:0]    shown_chars[$];

	string keyword_names [5] = '{"section", "subsection", "subsubsection", "newline", "item"};
	string keyword_texts [5] = '{"\n\n", "\n\n", "\n\n", "\n", "\n  * "};

	scan_mode_t            scan_mode = SCAN_TEXT;
	logic [7:0]            name_chars [MAX_NAME_LEN];
	int                    name_len = 0;
	bit                    name_ovf = 1'b0;
	logic [DEPTH_BITS-1:0] brace_level = '0;

	bit idling = 1'b1;
	int src_gap = 0;
	int sink_gap = 0;
	int stall_cycles = 0;
	int mismatches = 0;
	int queued_bytes = 0;

	latex_markup_stripper dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.s_axis_tlast(s_axis_tlast),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.m_axis_tuser(m_axis_tuser),
		.m_axis_tlast(m_axis_tlast)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	function automatic bit is_letter(input logic [7:0] c);
		return (c >= "A" && c <= "Z") || (c >= "a" && c <= "z");
	endfunction

	function automatic void copy_text_byte(input logic [7:0] c);
		if (c == CH_PERCENT) begin
			shown_chars.push_back(CH_LF);
			scan_mode = SCAN_COMMENT;
		end else if (c == CH_BSLASH) begin
			scan_mode = SCAN_NAME;
			name_len = 0;
			name_ovf = 1'b0;
		end else if (c == CH_LBRACE) begin
			if (brace_level != DEPTH_TOP)
				brace_level = brace_level + 1'b1;
			shown_chars.push_back(CH_LBRACE);
		end else if (c == CH_RBRACE) begin
			if (brace_level != '0) begin
				brace_level = brace_level - 1'b1;
				shown_chars.push_back(CH_RBRACE);
			end
		end else if (c != CH_DOLLAR) begin
			shown_chars.push_back(c);
		end
	endfunction

	function automatic void close_name();
		string word;
		string text;
		bit hit;
		scan_mode = SCAN_TEXT;
		if (!name_ovf) begin
			for (int k = 0; k < 5; k++) begin
				word = keyword_names[k];
				hit = (word.len() == name_len);
				for (int i = 0; i < name_len && hit; i++)
					if (name_chars[i] != word[i])
						hit = 1'b0;
				if (hit) begin
					text = keyword_texts[k];
					for (int i = 0; i < text.len(); i++)
						shown_chars.push_back(text[i]);
					break;
				end
			end
		end
	endfunction

	function automatic void strip_byte(input logic [7:0] c, input logic fin);
		int n;
		shown_chars.delete();
		case (scan_mode)
			SCAN_COMMENT: begin
				if (c == CH_LF)
					scan_mode = SCAN_TEXT;
			end
			SCAN_NAME: begin
				if (is_letter(c)) begin
					if (name_len < MAX_NAME_LEN) begin
						name_chars[name_len] = c;
						name_len++;
					end else begin
						name_ovf = 1'b1;
					end
					if (fin)
						close_name();
				end else begin
					close_name();
					copy_text_byte(c);
				end
			end
			default: copy_text_byte(c);
		endcase
		if (fin) begin
			scan_mode = SCAN_TEXT;
			name_len = 0;
			name_ovf = 1'b0;
			brace_level = '0;
		end
		n = shown_chars.size();
		for (int i = 0; i < n; i++)
			display_words.push_back('{shown_chars[i], 1'b1, i == n - 1, fin && i == n - 1});
		if (n == 0 && fin)
			display_words.push_back('{8'h00, 1'b0, 1'b1, 1'b1});
	endfunction

	task automatic report_mismatch(input string what);
		mismatches++;
		if (mismatches <= 40)
			$display("mismatch at %0t ns: %s", $time, what);
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_axis_tvalid <= 1'b0;
			s_axis_tdata <= 8'h00;
			s_axis_tlast <= 1'b0;
			src_gap = 0;
		end else begin
			if (s_axis_tvalid && s_axis_tready)
				strip_byte(s_axis_tdata, s_axis_tlast);
			if (!s_axis_tvalid || s_axis_tready) begin
				if (src_gap > 0) begin
					src_gap--;
					s_axis_tvalid <= 1'b0;
				end else if (idling && $urandom_range(0, 9) == 0) begin
					src_gap = $urandom_range(0, 17);
					s_axis_tvalid <= 1'b0;
				end else if (source_bytes.size() > 0) begin
					s_axis_tvalid <= 1'b1;
					s_axis_tdata <= source_bytes[0].ch;
					s_axis_tlast <= source_bytes[0].fin;
					source_bytes.pop_front();
				end else begin
					s_axis_tvalid <= 1'b0;
				end
			end
		end
	end

	always @(posedge clk or negedge arst_n) begin
		display_word_t got;
		display_word_t want;
		if (!arst_n) begin
			m_axis_tready <= 1'b0;
			sink_gap = 0;
		end else begin
			if (m_axis_tvalid && m_axis_tready) begin
				got = '{m_axis_tdata, m_axis_tuser[0], m_axis_tlast, m_axis_tuser[1]};
				if (display_words.size() == 0) begin
					report_mismatch($sformatf("word %02h arrived with nothing expected",
						got.out_char));
				end else begin
					want = display_words.pop_front();
					if (got.out_char != want.out_char)
						report_mismatch($sformatf("out_char %02h, expected %02h",
							got.out_char, want.out_char));
					if (got.char_valid != want.char_valid)
						report_mismatch($sformatf("char_valid %0b, expected %0b",
							got.char_valid, want.char_valid));
					if (got.run_last != want.run_last)
						report_mismatch($sformatf("run_last %0b, expected %0b",
							got.run_last, want.run_last));
					if (got.text_end != want.text_end)
						report_mismatch($sformatf("text_end %0b, expected %0b",
							got.text_end, want.text_end));
				end
			end
			if (sink_gap > 0) begin
				sink_gap--;
				m_axis_tready <= 1'b0;
			end else if (idling && $urandom_range(0, 9) == 0) begin
				sink_gap = $urandom_range(0, 17);
				m_axis_tready <= 1'b0;
			end else begin
				m_axis_tready <= 1'b1;
			end
		end
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stall_cycles <= 0;
		end else if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
			stall_cycles <= 0;
		end else begin
			stall_cycles <= stall_cycles + 1;
			if (stall_cycles >= STALL_LIMIT) begin
				$display("RESULT: ERROR");
				$finish;
			end
		end
	end

	task automatic queue_byte(input logic [7:0] c, input logic fin);
		source_bytes.push_back('{c, fin});
		queued_bytes++;
	endtask

	task automatic queue_text(input string s);
		for (int i = 0; i < s.len(); i++)
			queue_byte(s[i], 1'b0);
	endtask

	function automatic logic [7:0] random_letter();
		if ($urandom_range(0, 1) == 0)
			return 8'(8'h41 + $urandom_range(0, 25));
		return 8'(8'h61 + $urandom_range(0, 25));
	endfunction

	function automatic logic [7:0] random_non_letter();
		logic [7:0] c;
		c = 8'($urandom_range(0, 255));
		while (is_letter(c))
			c = 8'($urandom_range(0, 255));
		return c;
	endfunction

	task automatic queue_command();
		string word;
		int pick;
		logic [7:0] stop;
		queue_byte(CH_BSLASH, 1'b0);
		word = keyword_names[$urandom_range(0, 4)];
		pick = $urandom_range(0, 9);
		if (pick < 5) begin
			queue_text(word);
		end else if (pick == 5) begin
			queue_text(word.substr(0, word.len() - 2));
		end else if (pick == 6) begin
			queue_text(word);
			queue_byte(random_letter(), 1'b0);
		end else if (pick == 7) begin
			queue_byte(word[0] - 8'h20, 1'b0);
			queue_text(word.substr(1, word.len() - 1));
		end else if (pick == 8) begin
			repeat ($urandom_range(0, 5))
				queue_byte(random_letter(), 1'b0);
		end else begin
			repeat ($urandom_range(MAX_NAME_LEN - 1, MAX_NAME_LEN + 4))
				queue_byte(random_letter(), 1'b0);
		end
		case ($urandom_range(0, 8))
			0: stop = CH_SPACE;
			1: stop = CH_LBRACE;
			2: stop = CH_RBRACE;
			3: stop = CH_BSLASH;
			4: stop = CH_PERCENT;
			5: stop = CH_DOLLAR;
			6: stop = CH_LF;
			7: stop = random_non_letter();
			default: stop = random_letter();
		endcase
		queue_byte(stop, $urandom_range(0, 9) == 0);
	endtask

	task automatic queue_token();
		int pick;
		logic [7:0] c;
		pick = $urandom_range(0, 99);
		if (pick < 30) begin
			queue_command();
		end else if (pick < 45) begin
			repeat ($urandom_range(1, 6))
				queue_byte(8'($urandom_range(8'h20, 8'h7E)), 1'b0);
		end else if (pick < 55) begin
			c = ($urandom_range(0, 1) == 0) ? CH_LBRACE : CH_RBRACE;
			repeat ($urandom_range(1, 3))
				queue_byte(c, 1'b0);
		end else if (pick < 65) begin
			queue_byte(CH_PERCENT, 1'b0);
			repeat ($urandom_range(0, 5))
				queue_byte(8'($urandom_range(0, 255)), 1'b0);
			queue_byte(CH_LF, 1'b0);
		end else if (pick < 72) begin
			queue_byte(CH_DOLLAR, 1'b0);
		end else if (pick < 87) begin
			queue_byte(8'($urandom_range(0, 255)), 1'b0);
		end else if (pick < 94) begin
			queue_byte(CH_BSLASH, 1'b0);
			queue_byte(8'($urandom_range(0, 255)), 1'b0);
		end else begin
			case ($urandom_range(0, 4))
				0: c = random_letter();
				1: c = CH_SPACE;
				2: c = CH_DOLLAR;
				3: c = CH_PERCENT;
				default: c = 8'($urandom_range(0, 255));
			endcase
			queue_byte(c, 1'b1);
		end
	endtask

	task automatic wait_drained();
		while (source_bytes.size() > 0 || s_axis_tvalid || display_words.size() > 0)
			@(negedge clk);
	endtask

	initial begin
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		queue_text("\\item}{}$%a\n\\\\x");
		queue_byte(8'h00, 1'b0);
		queue_byte(8'hFF, 1'b0);
		queue_text("\\newlin");
		queue_byte("e", 1'b1);
		wait_drained();

		idling = 1'b0;
		for (int i = 0; i < 6; i++)
			queue_byte(CH_LBRACE, 1'b0);
		queue_text("}}}");
		queue_byte(CH_RBRACE, 1'b1);
		wait_drained();

		idling = 1'b1;
		while (queued_bytes < 140)
			queue_token();
		wait_drained();

		idling = 1'b0;
		while (queued_bytes < 200)
			queue_token();
		wait_drained();

		repeat (DRAIN_CYCLES) @(negedge clk);
		if (display_words.size() != 0)
			report_mismatch($sformatf("%0d expected words never arrived", display_words.size()));
		if (mismatches == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule
